>>> src/assert_macros.svh
// Assertion helpers shared by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define WSWM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define WSWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/wswm_pkg.sv
`timescale 1ns / 1ps

package wswm_pkg;

  localparam int SLOTS_DEF  = 16;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;
  localparam int DAY_W      = 7;
  localparam int MIN_W      = 11;
  localparam int PRI_W      = 16;
  localparam int WDAY_W     = 3;
  localparam int DBIT_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [DBIT_W-1:0] SUNDAY_BIT = DBIT_W'(6);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PICK_PRIO   = CFG_IDX_W'(1);

  typedef struct packed {
    logic [DAY_W-1:0] days;
    logic [MIN_W-1:0] start_min;
    logic [MIN_W-1:0] stop_min;
    logic [PRI_W-1:0] prio;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic [DBIT_W-1:0] day_bit;
    logic [MIN_W-1:0]  minute;
    logic              pick_prio;
  } qry_t;

  typedef struct packed {
    logic             found;
    logic [PRI_W-1:0] prio;
  } best_t;

  // Sunday-first weekday to Monday-first mask bit; seven folds onto Sunday
  function automatic logic [DBIT_W-1:0] day_bit(input logic [WDAY_W-1:0] wd);
    logic [DBIT_W-1:0] b;
    if (wd == WDAY_W'(0) || wd == WDAY_W'(7)) begin
      b = SUNDAY_BIT;
    end else begin
      b = DBIT_W'(wd - WDAY_W'(1));
    end
    return b;
  endfunction

endpackage

>>> src/weekly_schedule_window_matcher.sv
`timescale 1ns / 1ps
// Write transaction: accepted without a stall, no result.
// Query: scans n = min(entry_count, SLOTS) entries, one RAM read per entry, then
// presents the result; next query accepted once the result is registered, later if stalled.
// Invalid time or n of zero: no RAM read; the query goes straight to ST_DONE, no match.
// Reset (synchronous, rst_n low) clears all enable bits, entry_count to 0 and
// pick_highest_priority to 1; slot contents stay undefined until written.

module weekly_schedule_window_matcher #(
  parameter int SLOTS = wswm_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_command,
  input  logic [wswm_pkg::IDX_W-1:0]      in_entry_index,
  input  logic                            in_entry_enabled,
  input  logic [wswm_pkg::DAY_W-1:0]      in_entry_days,
  input  logic [wswm_pkg::MIN_W-1:0]      in_entry_start,
  input  logic [wswm_pkg::MIN_W-1:0]      in_entry_end,
  input  logic [wswm_pkg::PRI_W-1:0]      in_entry_priority,
  input  logic [wswm_pkg::WDAY_W-1:0]     in_weekday,
  input  logic [wswm_pkg::MIN_W-1:0]      in_minute_of_day,
  input  logic                            in_time_valid,

  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_match_found,
  output logic [wswm_pkg::IDX_W-1:0]      out_match_index,

  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wswm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wswm_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t                         state_r, state_nxt;
  logic [wswm_pkg::CNT_W-1:0]     count_r;
  logic                           pick_r;
  logic [SLOTS-1:0]               en_r;
  logic [CW-1:0]                  scan_n_r, scan_n_nxt;
  logic [CW-1:0]                  issue_r, issue_nxt;
  logic                           eval_vld_r, eval_vld_nxt;
  logic [AW-1:0]                  eval_idx_r, eval_idx_nxt;
  wswm_pkg::qry_t                 qry_r, qry_nxt;
  wswm_pkg::best_t                best_r, best_nxt;
  logic [AW-1:0]                  best_idx_r, best_idx_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_found_r, out_found_nxt;
  logic [wswm_pkg::IDX_W-1:0]     out_index_r, out_index_nxt;

  logic                           in_acc;
  logic                           qry_acc;
  logic                           wr_en;
  logic [AW-1:0]                  wr_addr;
  logic [AW-1:0]                  ram_addr;
  wswm_pkg::slot_t                wr_slot;
  logic [wswm_pkg::SLOT_W-1:0]    ram_rdata;
  wswm_pkg::slot_t                rd_slot;
  logic                           take;
  logic [CW-1:0]                  n_eff;
  logic                           out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign qry_acc   = in_acc && (in_command == wswm_pkg::CMD_QUERY);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign wr_addr = AW'(in_entry_index);
  assign wr_en   = in_acc && (in_command == wswm_pkg::CMD_WRITE)
                   && (32'(in_entry_index) < SLOTS);

  assign wr_slot.days      = in_entry_days;
  assign wr_slot.start_min = in_entry_start;
  assign wr_slot.stop_min  = in_entry_end;
  assign wr_slot.prio      = in_entry_priority;

  assign ram_addr = wr_en ? wr_addr : issue_r[AW-1:0];

  wswm_ram #(
    .WIDTH  (wswm_pkg::SLOT_W),
    .DEPTH  (SLOTS),
    .ADDR_W (AW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (wr_en),
    .addr  (ram_addr),
    .wdata (wr_slot),
    .rdata (ram_rdata)
  );

  assign rd_slot = wswm_pkg::slot_t'(ram_rdata);

  wswm_match u_match (
    .slot    (rd_slot),
    .slot_en (en_r[eval_idx_r]),
    .qry     (qry_r),
    .best    (best_r),
    .take    (take)
  );

  always_comb begin
    if (32'(count_r) > SLOTS) begin
      n_eff = CW'(SLOTS);
    end else begin
      n_eff = CW'(count_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    scan_n_nxt    = scan_n_r;
    issue_nxt     = issue_r;
    eval_vld_nxt  = 1'b0;
    eval_idx_nxt  = eval_idx_r;
    qry_nxt       = qry_r;
    best_nxt      = best_r;
    best_idx_nxt  = best_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    out_index_nxt = out_index_r;

    case (state_r)
      ST_IDLE: begin
        if (qry_acc) begin
          qry_nxt.day_bit   = wswm_pkg::day_bit(in_weekday);
          qry_nxt.minute    = in_minute_of_day;
          qry_nxt.pick_prio = pick_r;
          best_nxt.found    = 1'b0;
          best_nxt.prio     = '0;
          best_idx_nxt      = '0;
          scan_n_nxt        = n_eff;
          issue_nxt         = '0;
          if (!in_time_valid || n_eff == '0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (eval_vld_r && take) begin
          best_nxt.found = 1'b1;
          best_nxt.prio  = rd_slot.prio;
          best_idx_nxt   = eval_idx_r;
        end
        if (issue_r < scan_n_r) begin
          eval_vld_nxt = 1'b1;
          eval_idx_nxt = issue_r[AW-1:0];
          issue_nxt    = issue_r + CW'(1);
        end else if (eval_vld_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = best_r.found;
          out_index_nxt = best_r.found ? wswm_pkg::IDX_W'(best_idx_r) : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      eval_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      en_r        <= '0;
      count_r     <= '0;
      pick_r      <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      eval_vld_r  <= eval_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        en_r[wr_addr] <= in_entry_enabled;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wswm_pkg::CFG_ENTRY_COUNT: count_r <= cfg_data[wswm_pkg::CNT_W-1:0];
          wswm_pkg::CFG_PICK_PRIO:   pick_r  <= cfg_data[0];
          default: ;
        endcase
      end
    end
    scan_n_r    <= scan_n_nxt;
    issue_r     <= issue_nxt;
    eval_idx_r  <= eval_idx_nxt;
    qry_r       <= qry_nxt;
    best_r      <= best_nxt;
    best_idx_r  <= best_idx_nxt;
    out_found_r <= out_found_nxt;
    out_index_r <= out_index_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_match_found = out_found_r;
  assign out_match_index = out_index_r;

  `include "assert_macros.svh"

  `WSWM_ASSERT_NOW(a_not_found_zero_index, out_valid && !out_match_found, out_match_index == '0)
  `WSWM_ASSERT_NOW(a_issue_bounded, state_r == ST_SCAN, issue_r <= scan_n_r)
  `WSWM_ASSERT_NOW(a_best_in_range, state_r == ST_DONE && best_r.found, CW'(best_idx_r) < scan_n_r)
  `WSWM_ASSERT_NEXT(a_invalid_time_skips, qry_acc && !in_time_valid, state_r == ST_DONE)

endmodule

>>> src/wswm_ram.sv
`timescale 1ns / 1ps

module wswm_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/wswm_match.sv
`timescale 1ns / 1ps

module wswm_match (
  input  wswm_pkg::slot_t slot,
  input  logic            slot_en,
  input  wswm_pkg::qry_t  qry,
  input  wswm_pkg::best_t best,
  output logic            take
);

  logic day_ok;
  logic win_ok;
  logic hit;

  assign day_ok = slot.days[qry.day_bit];

  always_comb begin
    if (slot.start_min == slot.stop_min) begin
      win_ok = 1'b0;
    end else if (slot.start_min < slot.stop_min) begin
      win_ok = (qry.minute >= slot.start_min) && (qry.minute < slot.stop_min);
    end else begin
      // wraps past midnight
      win_ok = (qry.minute >= slot.start_min) || (qry.minute < slot.stop_min);
    end
  end

  assign hit = slot_en && day_ok && win_ok;

  always_comb begin
    if (!hit) begin
      take = 1'b0;
    end else if (!best.found) begin
      take = 1'b1;
    end else begin
      take = qry.pick_prio && (slot.prio > best.prio);
    end
  end

endmodule

>>> test/weekly_schedule_window_matcher_test.sv
`timescale 1ns / 1ps

module weekly_schedule_window_matcher_test;
  import wswm_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES = 7;

  typedef struct {
    logic              cmd;
    logic [IDX_W-1:0]  slot;
    logic              enable;
    logic [DAY_W-1:0]  days;
    logic [MIN_W-1:0]  start_min;
    logic [MIN_W-1:0]  end_min;
    logic [PRI_W-1:0]  prio;
    logic [WDAY_W-1:0] weekday;
    logic [MIN_W-1:0]  minute;
    logic              time_ok;
  } sched_item_t;

  typedef struct {
    logic             found;
    logic [IDX_W-1:0] slot;
  } lookup_t;

  class schedule_scoreboard;
    bit               slot_on[SLOTS_DEF];
    logic [DAY_W-1:0] slot_days[SLOTS_DEF];
    logic [MIN_W-1:0] slot_start[SLOTS_DEF];
    logic [MIN_W-1:0] slot_end[SLOTS_DEF];
    logic [PRI_W-1:0] slot_prio[SLOTS_DEF];
    int unsigned      active_count;
    bit               prefer_priority;
    lookup_t          pending_lookups[$];
    int               errors;
    int               writes;
    int               queries;
    int               hits_seen;

    function new();
      foreach (slot_on[i]) slot_on[i] = 1'b0;
      active_count = 0;
      prefer_priority = 1'b1;
      errors = 0;
      writes = 0;
      queries = 0;
      hits_seen = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_ENTRY_COUNT) begin
        active_count = value;
      end else if (idx == CFG_PICK_PRIO) begin
        prefer_priority = value[0];
      end
    endfunction

    function bit in_window(logic [MIN_W-1:0] s, logic [MIN_W-1:0] e, logic [MIN_W-1:0] m);
      if (s == e) return 1'b0;
      if (s < e) return (m >= s) && (m < e);
      return (m >= s) || (m < e);
    endfunction

    function void note_input(sched_item_t it);
      lookup_t          res;
      logic [PRI_W-1:0] best_prio;
      int unsigned      n;
      int unsigned      dbit;
      if (it.cmd == CMD_WRITE) begin
        slot_on[it.slot] = it.enable;
        slot_days[it.slot] = it.days;
        slot_start[it.slot] = it.start_min;
        slot_end[it.slot] = it.end_min;
        slot_prio[it.slot] = it.prio;
        writes++;
        return;
      end
      queries++;
      res.found = 1'b0;
      res.slot = '0;
      best_prio = '0;
      n = (active_count > SLOTS_DEF) ? SLOTS_DEF : active_count;
      dbit = (it.weekday == 0 || it.weekday == 7) ? int'(SUNDAY_BIT) : it.weekday - 1;
      if (it.time_ok && n > 0) begin
        for (int i = 0; i < n; i++) begin
          if (!slot_on[i] || !slot_days[i][dbit]) continue;
          if (!in_window(slot_start[i], slot_end[i], it.minute)) continue;
          if (!prefer_priority) begin
            res.found = 1'b1;
            res.slot = IDX_W'(i);
            break;
          end
          if (!res.found || slot_prio[i] > best_prio) begin
            res.found = 1'b1;
            res.slot = IDX_W'(i);
            best_prio = slot_prio[i];
          end
        end
      end
      pending_lookups.push_back(res);
    endfunction

    function void check_result(logic found, logic [IDX_W-1:0] slot);
      lookup_t want;
      if (pending_lookups.size() == 0) begin
        $error("unexpected result: match_found %0d match_index %0d", found, slot);
        errors++;
        return;
      end
      want = pending_lookups.pop_front();
      if (found !== want.found) begin
        $error("match_found: expected %0d, got %0d", want.found, found);
        errors++;
      end
      if (slot !== want.slot) begin
        $error("match_index: expected %0d, got %0d", want.slot, slot);
        errors++;
      end
      if (found === 1'b1) hits_seen++;
    endfunction

    function int pending();
      return pending_lookups.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_command;
  logic [IDX_W-1:0]      in_entry_index;
  logic                  in_entry_enabled;
  logic [DAY_W-1:0]      in_entry_days;
  logic [MIN_W-1:0]      in_entry_start;
  logic [MIN_W-1:0]      in_entry_end;
  logic [PRI_W-1:0]      in_entry_priority;
  logic [WDAY_W-1:0]     in_weekday;
  logic [MIN_W-1:0]      in_minute_of_day;
  logic                  in_time_valid;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_match_found;
  logic [IDX_W-1:0]      out_match_index;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  schedule_scoreboard book;
  bit                 idle_on;
  int                 cycle_count;

  weekly_schedule_window_matcher uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_entry_index    (in_entry_index),
    .in_entry_enabled  (in_entry_enabled),
    .in_entry_days     (in_entry_days),
    .in_entry_start    (in_entry_start),
    .in_entry_end      (in_entry_end),
    .in_entry_priority (in_entry_priority),
    .in_weekday        (in_weekday),
    .in_minute_of_day  (in_minute_of_day),
    .in_time_valid     (in_time_valid),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_match_found   (out_match_found),
    .out_match_index   (out_match_index),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) book.check_result(out_match_found, out_match_index);
  end

  // Receiver back-pressure in bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input sched_item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= it.cmd;
    in_entry_index <= it.slot;
    in_entry_enabled <= it.enable;
    in_entry_days <= it.days;
    in_entry_start <= it.start_min;
    in_entry_end <= it.end_min;
    in_entry_priority <= it.prio;
    in_weekday <= it.weekday;
    in_minute_of_day <= it.minute;
    in_time_valid <= it.time_ok;
    do @(posedge clk); while (in_stall);
    book.note_input(it);
    @(negedge clk);
  endtask

  task automatic send_entry(input int slot, input bit en, input int days, input int s,
                            input int e, input int prio);
    sched_item_t it;
    it = '{default: '0};
    it.cmd = CMD_WRITE;
    it.slot = IDX_W'(slot);
    it.enable = en;
    it.days = DAY_W'(days);
    it.start_min = MIN_W'(s);
    it.end_min = MIN_W'(e);
    it.prio = PRI_W'(prio);
    send_item(it);
  endtask

  task automatic send_query(input int wd, input int minute, input bit ok);
    sched_item_t it;
    it = '{default: '0};
    it.cmd = CMD_QUERY;
    it.weekday = WDAY_W'(wd);
    it.minute = MIN_W'(minute);
    it.time_ok = ok;
    send_item(it);
  endtask

  // Hold the sender until every lookup has come back, then let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_registers(input int unsigned count, input bit prefer);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_ENTRY_COUNT;
    cfg_data <= CFG_DATA_W'(count);
    do @(posedge clk); while (!cfg_ready);
    book.set_register(CFG_ENTRY_COUNT, CFG_DATA_W'(count));
    @(negedge clk);
    cfg_index <= CFG_PICK_PRIO;
    cfg_data <= CFG_DATA_W'(prefer);
    do @(posedge clk); while (!cfg_ready);
    book.set_register(CFG_PICK_PRIO, CFG_DATA_W'(prefer));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic sched_item_t random_item();
    sched_item_t it;
    it.cmd = ($urandom_range(0, 9) < 4) ? CMD_WRITE : CMD_QUERY;
    it.slot = IDX_W'($urandom_range(0, 15));
    it.enable = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 1) == 0) it.days = '1;
    else it.days = DAY_W'($urandom_range(0, 127));
    if ($urandom_range(0, 15) == 0) it.start_min = MIN_W'($urandom_range(0, 2047));
    else it.start_min = MIN_W'($urandom_range(0, 1440));
    if ($urandom_range(0, 15) == 0) it.end_min = MIN_W'($urandom_range(0, 2047));
    else it.end_min = MIN_W'($urandom_range(0, 1440));
    if ($urandom_range(0, 1) == 0) it.prio = PRI_W'($urandom_range(0, 7));
    else it.prio = PRI_W'($urandom_range(0, 65535));
    it.weekday = WDAY_W'($urandom_range(0, 7));
    if ($urandom_range(0, 15) == 0) it.minute = MIN_W'($urandom_range(0, 2047));
    else it.minute = MIN_W'($urandom_range(0, 1439));
    it.time_ok = ($urandom_range(0, 9) != 0);
    return it;
  endfunction

  initial begin
    int unsigned phase_count[PHASES];
    bit          phase_prefer[PHASES];
    int          phase_items[PHASES];
    int          settings;
    book = new();
    cycle_count = 0;
    idle_on = 1'b1;
    settings = 1;
    phase_count = '{16, 5, 31, 1, 0, 12, 16};
    phase_prefer = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    phase_items = '{100, 80, 80, 60, 30, 80, 70};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_WRITE;
    in_entry_index = '0;
    in_entry_enabled = 1'b0;
    in_entry_days = '0;
    in_entry_start = '0;
    in_entry_end = '0;
    in_entry_priority = '0;
    in_weekday = '0;
    in_minute_of_day = '0;
    in_time_valid = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ENTRY_COUNT;
    cfg_data = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // empty table right after reset
    send_query(3, 720, 1'b1);
    send_entry(0, 1'b1, 'h7F, 0, 1440, 0);
    send_entry(1, 1'b0, 'h7F, 0, 1440, 65535);
    send_entry(2, 1'b1, 'h40, 1320, 360, 100);
    send_entry(3, 1'b1, 'h7F, 600, 600, 65535);
    send_entry(4, 1'b1, 'h00, 0, 1440, 65535);
    send_entry(5, 1'b1, 'h01, 480, 1020, 65535);
    send_entry(6, 1'b1, 'h7F, 1439, 1440, 200);
    send_entry(7, 1'b1, 'h7F, 2047, 0, 300);
    for (int i = 8; i < SLOTS_DEF; i++) send_entry(i, 1'b1, 'h3E, 0, 2047, 50);
    drain_results();
    write_registers(16, 1'b1);
    send_query(0, 0, 1'b1);
    send_query(7, 1400, 1'b1);
    send_query(1, 600, 1'b1);
    send_query(2, 1439, 1'b1);
    send_query(3, 2047, 1'b1);
    send_query(4, 0, 1'b1);
    send_query(5, 720, 1'b0);
    send_query(6, 100, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      idle_on = (p != PHASES - 1);
      write_registers(phase_count[p], phase_prefer[p]);
      settings++;
      for (int k = 0; k < phase_items[p]; k++) begin
        if (p == 0 && k == phase_items[p] / 2) drain_results();
        send_item(random_item());
      end
    end
    drain_results();

    $display("Ran %0d table writes and %0d lookups (%0d hits) across %0d register settings,",
             book.writes, book.queries, book.hits_seen, settings);
    $display("including empty, oversized and single-entry tables in both selection modes.");
    if (book.errors == 0 && book.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/wswm_pkg.sv
src/wswm_ram.sv
src/wswm_match.sv
src/weekly_schedule_window_matcher.sv
test/weekly_schedule_window_matcher_test.sv
